// ===== design/pqa_pkg.sv =====
// Shared widths, constants, tables and types for the plane quadric accumulator.
package pqa_pkg;

  localparam int unsigned POS_FRAC_BITS = 8;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned NRM_W    = 24;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned N2_W     = 48;
  localparam int unsigned W_W      = 42;
  localparam int unsigned MAG_W    = 40;
  localparam int unsigned MUL_HW   = 20;
  localparam int unsigned PROD_W   = 2 * MAG_W;
  localparam int unsigned QUOT_W   = 48;
  localparam int unsigned NUM_SUMS = 10;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [1:0]       pidx_t;
  typedef logic [2:0]       step_t;
  typedef logic [3:0]       sidx_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam pidx_t P_X = 2'd0;
  localparam pidx_t P_Y = 2'd1;
  localparam pidx_t P_Z = 2'd2;
  localparam pidx_t P_W = 2'd3;

  localparam step_t FIRST_W_STEP = 3'd3;
  localparam step_t LAST_STEP    = 3'd5;
  localparam sidx_t LAST_SUM     = 4'd9;

  localparam pidx_t PAIR_I [NUM_SUMS] = '{P_X, P_X, P_X, P_X, P_Y, P_Y, P_Y, P_Z, P_Z, P_W};
  localparam pidx_t PAIR_J [NUM_SUMS] = '{P_X, P_Y, P_Z, P_W, P_Y, P_Z, P_W, P_Z, P_W, P_W};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSTART,
    ST_PMUL,
    ST_TSTART,
    ST_TMUL,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } pqa_state_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic busy;
    logic emit;
  } pqa_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== design/plane_quadric_accumulator.sv =====
// Top level: sequencer, plane and sum registers, and the output register.
// A request with a face first forms |n|^2 and w, then one multiply and one divide per quadric entry.
// All ten entries share the one 48-step divider; a zero normal skips the entries, no face skips all.
// One request is worked on at a time; the result waits in an output register, so the
// next request is taken while it is stalled. Reset clears the sums, the saturation flag
// and all control state.
module plane_quadric_accumulator #(
  parameter int unsigned SUM_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [15:0]  pos_z_i,
  input  logic signed [23:0]  normal_x_i,
  input  logic signed [23:0]  normal_y_i,
  input  logic signed [23:0]  normal_z_i,
  input  logic                face_valid_i,
  input  logic                last_face_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [47:0]  q_xx_o,
  output logic signed [47:0]  q_xy_o,
  output logic signed [47:0]  q_xz_o,
  output logic signed [47:0]  q_xw_o,
  output logic signed [47:0]  q_yy_o,
  output logic signed [47:0]  q_yz_o,
  output logic signed [47:0]  q_yw_o,
  output logic signed [47:0]  q_zz_o,
  output logic signed [47:0]  q_zw_o,
  output logic signed [47:0]  q_ww_o,
  output logic                saturated_o
);

  localparam int unsigned DVD_W = pqa_pkg::PROD_W + SUM_FRAC_BITS;

  pqa_pkg::pqa_state_e  state_q, state_d;
  pqa_pkg::pqa_ctl_t    ctl;
  pqa_pkg::step_t       step_q;
  pqa_pkg::sidx_t       k_q;
  logic                 last_q;
  logic                 sat_q;
  pqa_pkg::sum_t        sums_q [pqa_pkg::NUM_SUMS];
  pqa_pkg::sum_t        out_sums_q [pqa_pkg::NUM_SUMS];
  logic                 out_sat_q;
  logic                 out_valid_q;

  logic [pqa_pkg::POS_W-1:0]   pos_x_q, pos_y_q, pos_z_q;
  logic [pqa_pkg::NRM_W-1:0]   nrm_x_q, nrm_y_q, nrm_z_q;
  logic [pqa_pkg::N2_W-1:0]    n2_q;
  logic [pqa_pkg::W_W-1:0]     w_q;

  logic                        in_accept;
  logic                        out_free;
  logic [pqa_pkg::NRM_W-1:0]   nmag_x, nmag_y, nmag_z;
  logic [pqa_pkg::POS_W-1:0]   pmag_x, pmag_y, pmag_z;
  logic [pqa_pkg::MAG_W-1:0]   wmag;
  logic [1:0]                  prep_idx;
  logic [pqa_pkg::NRM_W-1:0]   prep_n;
  logic [pqa_pkg::POS_W-1:0]   prep_p;
  logic                        prep_neg;
  pqa_pkg::pidx_t              sel_i, sel_j;
  logic [pqa_pkg::MAG_W-1:0]   pm_a, pm_b;
  logic                        ps_a, ps_b;
  logic [pqa_pkg::MAG_W-1:0]   mul_a, mul_b;
  logic                        mul_done;
  logic [pqa_pkg::PROD_W-1:0]  mul_prod;
  logic [DVD_W-1:0]            dvd_full;
  logic [DVD_W-1:0]            dvd;
  pqa_pkg::div_stat_t          div_stat;
  logic [pqa_pkg::QUOT_W-1:0]  div_quot;
  logic                        neg;
  pqa_pkg::sum_t               lim;
  logic                        tsat;
  pqa_pkg::sum_t               qm;
  pqa_pkg::sum_t               term;
  pqa_pkg::sum_t               sum_cur;
  logic [pqa_pkg::SUM_W:0]     sum_wide;
  logic                        ssat;
  pqa_pkg::sum_t               sum_new;

  function automatic logic [pqa_pkg::NRM_W-1:0] mag_n(logic [pqa_pkg::NRM_W-1:0] v);
    return v[pqa_pkg::NRM_W-1] ? pqa_pkg::NRM_W'('0 - v) : v;
  endfunction

  function automatic logic [pqa_pkg::POS_W-1:0] mag_p(logic [pqa_pkg::POS_W-1:0] v);
    return v[pqa_pkg::POS_W-1] ? pqa_pkg::POS_W'('0 - v) : v;
  endfunction

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign nmag_x = mag_n(nrm_x_q);
  assign nmag_y = mag_n(nrm_y_q);
  assign nmag_z = mag_n(nrm_z_q);
  assign pmag_x = mag_p(pos_x_q);
  assign pmag_y = mag_p(pos_y_q);
  assign pmag_z = mag_p(pos_z_q);
  assign wmag   = w_q[pqa_pkg::W_W-1] ? pqa_pkg::MAG_W'(pqa_pkg::W_W'(0) - w_q)
                                      : w_q[pqa_pkg::MAG_W-1:0];

  assign prep_idx = (step_q >= pqa_pkg::FIRST_W_STEP) ? 2'(step_q - pqa_pkg::FIRST_W_STEP)
                                                      : step_q[1:0];

  always_comb begin
    case (prep_idx)
      pqa_pkg::P_X: begin
        prep_n   = nmag_x;
        prep_p   = pmag_x;
        prep_neg = nrm_x_q[pqa_pkg::NRM_W-1] ^ pos_x_q[pqa_pkg::POS_W-1];
      end
      pqa_pkg::P_Y: begin
        prep_n   = nmag_y;
        prep_p   = pmag_y;
        prep_neg = nrm_y_q[pqa_pkg::NRM_W-1] ^ pos_y_q[pqa_pkg::POS_W-1];
      end
      default: begin
        prep_n   = nmag_z;
        prep_p   = pmag_z;
        prep_neg = nrm_z_q[pqa_pkg::NRM_W-1] ^ pos_z_q[pqa_pkg::POS_W-1];
      end
    endcase
  end

  assign sel_i = pqa_pkg::PAIR_I[k_q];
  assign sel_j = pqa_pkg::PAIR_J[k_q];

  always_comb begin
    case (sel_i)
      pqa_pkg::P_X: begin pm_a = pqa_pkg::MAG_W'(nmag_x); ps_a = nrm_x_q[pqa_pkg::NRM_W-1]; end
      pqa_pkg::P_Y: begin pm_a = pqa_pkg::MAG_W'(nmag_y); ps_a = nrm_y_q[pqa_pkg::NRM_W-1]; end
      pqa_pkg::P_Z: begin pm_a = pqa_pkg::MAG_W'(nmag_z); ps_a = nrm_z_q[pqa_pkg::NRM_W-1]; end
      default:      begin pm_a = wmag;                    ps_a = w_q[pqa_pkg::W_W-1];       end
    endcase
    case (sel_j)
      pqa_pkg::P_X: begin pm_b = pqa_pkg::MAG_W'(nmag_x); ps_b = nrm_x_q[pqa_pkg::NRM_W-1]; end
      pqa_pkg::P_Y: begin pm_b = pqa_pkg::MAG_W'(nmag_y); ps_b = nrm_y_q[pqa_pkg::NRM_W-1]; end
      pqa_pkg::P_Z: begin pm_b = pqa_pkg::MAG_W'(nmag_z); ps_b = nrm_z_q[pqa_pkg::NRM_W-1]; end
      default:      begin pm_b = wmag;                    ps_b = w_q[pqa_pkg::W_W-1];       end
    endcase
  end

  always_comb begin
    if (state_q == pqa_pkg::ST_TSTART) begin
      mul_a = pm_a;
      mul_b = pm_b;
    end else begin
      mul_a = pqa_pkg::MAG_W'(prep_n);
      mul_b = (step_q >= pqa_pkg::FIRST_W_STEP) ? pqa_pkg::MAG_W'(prep_p)
                                                : pqa_pkg::MAG_W'(prep_n);
    end
  end

  pqa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign dvd_full = {mul_prod, {SUM_FRAC_BITS{1'b0}}};

  always_comb begin
    if ((sel_i == pqa_pkg::P_W) && (sel_j == pqa_pkg::P_W)) begin
      dvd = dvd_full >> (2 * pqa_pkg::POS_FRAC_BITS);
    end else if ((sel_i == pqa_pkg::P_W) || (sel_j == pqa_pkg::P_W)) begin
      dvd = dvd_full >> pqa_pkg::POS_FRAC_BITS;
    end else begin
      dvd = dvd_full;
    end
  end

  pqa_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (dvd),
    .divisor_i  (n2_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // The term is clamped to the signed 48-bit range before it is added.
  always_comb begin
    neg      = ps_a ^ ps_b;
    lim      = neg ? pqa_pkg::SUM_MIN : pqa_pkg::SUM_MAX;
    tsat     = div_stat.ovf || (div_quot > lim);
    qm       = tsat ? lim : div_quot;
    term     = neg ? pqa_pkg::SUM_W'('0 - qm) : qm;
    sum_cur  = sums_q[k_q];
    sum_wide = {sum_cur[pqa_pkg::SUM_W-1], sum_cur} + {term[pqa_pkg::SUM_W-1], term};
    ssat     = sum_wide[pqa_pkg::SUM_W] != sum_wide[pqa_pkg::SUM_W-1];
    if (ssat) begin
      sum_new = sum_wide[pqa_pkg::SUM_W] ? pqa_pkg::SUM_MIN : pqa_pkg::SUM_MAX;
    end else begin
      sum_new = sum_wide[pqa_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pqa_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = face_valid_i ? pqa_pkg::ST_PSTART : pqa_pkg::ST_DONE;
        end
      end
      pqa_pkg::ST_PSTART: state_d = pqa_pkg::ST_PMUL;
      pqa_pkg::ST_PMUL: begin
        if (mul_done) begin
          if (step_q != pqa_pkg::LAST_STEP) begin
            state_d = pqa_pkg::ST_PSTART;
          end else if (n2_q == '0) begin
            state_d = pqa_pkg::ST_DONE;
          end else begin
            state_d = pqa_pkg::ST_TSTART;
          end
        end
      end
      pqa_pkg::ST_TSTART: state_d = pqa_pkg::ST_TMUL;
      pqa_pkg::ST_TMUL: begin
        if (mul_done) begin
          state_d = pqa_pkg::ST_DSTART;
        end
      end
      pqa_pkg::ST_DSTART: state_d = pqa_pkg::ST_DIV;
      pqa_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = (k_q == pqa_pkg::LAST_SUM) ? pqa_pkg::ST_DONE : pqa_pkg::ST_TSTART;
        end
      end
      pqa_pkg::ST_DONE: begin
        if (!last_q || out_free) begin
          state_d = pqa_pkg::ST_IDLE;
        end
      end
      default: state_d = pqa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_q)
      pqa_pkg::ST_IDLE:   ctl.busy = 1'b0;
      pqa_pkg::ST_PSTART: begin ctl.busy = 1'b1; ctl.mul_start = 1'b1; end
      pqa_pkg::ST_TSTART: begin ctl.busy = 1'b1; ctl.mul_start = 1'b1; end
      pqa_pkg::ST_DSTART: begin ctl.busy = 1'b1; ctl.div_start = 1'b1; end
      pqa_pkg::ST_DONE:   begin ctl.busy = 1'b1; ctl.emit = last_q && out_free; end
      default:            ctl.busy = 1'b1;
    endcase
  end

  assign in_stall_o = ctl.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqa_pkg::ST_IDLE;
      step_q      <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pqa_pkg::NUM_SUMS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        step_q <= '0;
        k_q    <= '0;
        last_q <= last_face_i;
      end
      if ((state_q == pqa_pkg::ST_PMUL) && mul_done && (step_q != pqa_pkg::LAST_STEP)) begin
        step_q <= step_q + 1'b1;
      end
      if ((state_q == pqa_pkg::ST_DIV) && div_stat.done) begin
        sums_q[k_q] <= sum_new;
        if (tsat || ssat) begin
          sat_q <= 1'b1;
        end
        if (k_q != pqa_pkg::LAST_SUM) begin
          k_q <= k_q + 1'b1;
        end
      end
      if (ctl.emit) begin
        sat_q <= 1'b0;
        for (int i = 0; i < pqa_pkg::NUM_SUMS; i++) begin
          sums_q[i] <= '0;
        end
      end
      if (ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      nrm_x_q <= normal_x_i;
      nrm_y_q <= normal_y_i;
      nrm_z_q <= normal_z_i;
      n2_q    <= '0;
      w_q     <= '0;
    end else if ((state_q == pqa_pkg::ST_PMUL) && mul_done) begin
      if (step_q < pqa_pkg::FIRST_W_STEP) begin
        n2_q <= n2_q + mul_prod[pqa_pkg::N2_W-1:0];
      end else if (prep_neg) begin
        w_q <= w_q + mul_prod[pqa_pkg::W_W-1:0];
      end else begin
        w_q <= w_q - mul_prod[pqa_pkg::W_W-1:0];
      end
    end
    if (ctl.emit) begin
      out_sums_q <= sums_q;
      out_sat_q  <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign q_xx_o      = out_sums_q[0];
  assign q_xy_o      = out_sums_q[1];
  assign q_xz_o      = out_sums_q[2];
  assign q_xw_o      = out_sums_q[3];
  assign q_yy_o      = out_sums_q[4];
  assign q_yz_o      = out_sums_q[5];
  assign q_yw_o      = out_sums_q[6];
  assign q_zz_o      = out_sums_q[7];
  assign q_zw_o      = out_sums_q[8];
  assign q_ww_o      = out_sums_q[9];
  assign saturated_o = out_sat_q;

endmodule

// ===== design/pqa_mul.sv =====
// Unsigned multiplier built from one 40 by 20 bit partial product, low half first, then high half.
module pqa_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pqa_pkg::MAG_W-1:0]   a_i,
  input  logic [pqa_pkg::MAG_W-1:0]   b_i,
  output logic                        done_o,
  output logic [pqa_pkg::PROD_W-1:0]  prod_o
);

  logic                                          ph_q;
  logic                                          done_q;
  logic [pqa_pkg::MAG_W-1:0]                     a_q;
  logic [pqa_pkg::MAG_W-pqa_pkg::MUL_HW-1:0]     bhi_q;
  logic [pqa_pkg::PROD_W-1:0]                    prod_q;
  logic [pqa_pkg::MAG_W-1:0]                     op_a;
  logic [pqa_pkg::MUL_HW-1:0]                    op_b;
  logic [pqa_pkg::MAG_W+pqa_pkg::MUL_HW-1:0]     pp;

  assign op_a = ph_q ? a_q : a_i;
  assign op_b = ph_q ? bhi_q : b_i[pqa_pkg::MUL_HW-1:0];
  assign pp   = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= start_i;
      done_q <= ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= pqa_pkg::PROD_W'(pp);
      a_q    <= a_i;
      bhi_q  <= b_i[pqa_pkg::MAG_W-1:pqa_pkg::MUL_HW];
    end else if (ph_q) begin
      prod_q <= prod_q + (pqa_pkg::PROD_W'(pp) << pqa_pkg::MUL_HW);
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== design/pqa_div.sv =====
// Restoring divider that yields one quotient bit per cycle and flags overflow.
module pqa_div #(
  parameter int unsigned DVD_W = 96
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DVD_W-1:0]            dividend_i,
  input  logic [pqa_pkg::N2_W-1:0]    divisor_i,
  output pqa_pkg::div_stat_t          stat_o,
  output logic [pqa_pkg::QUOT_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(pqa_pkg::QUOT_W + 1);

  logic                          busy_q;
  logic                          done_q;
  logic                          ovf_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [pqa_pkg::N2_W-1:0]      rem_q;
  logic [pqa_pkg::N2_W-1:0]      dsr_q;
  logic [pqa_pkg::QUOT_W-1:0]    quo_q;
  logic [pqa_pkg::N2_W:0]        trial;
  logic [pqa_pkg::N2_W:0]        diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[pqa_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(pqa_pkg::QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= pqa_pkg::N2_W'(dividend_i >> pqa_pkg::QUOT_W);
      quo_q <= dividend_i[pqa_pkg::QUOT_W-1:0];
      dsr_q <= divisor_i;
      ovf_q <= (dividend_i >> pqa_pkg::QUOT_W) >= DVD_W'(divisor_i);
    end else if (busy_q) begin
      rem_q <= ge ? diff[pqa_pkg::N2_W-1:0] : trial[pqa_pkg::N2_W-1:0];
      quo_q <= {quo_q[pqa_pkg::QUOT_W-2:0], ge};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quot_o      = quo_q;

endmodule

// ===== design/pqa_chk.sv =====
// Port-level checker for the plane quadric accumulator and its bind.
module pqa_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic signed [47:0]  q_xx_o,
  input logic signed [47:0]  q_xy_o,
  input logic signed [47:0]  q_xz_o,
  input logic signed [47:0]  q_xw_o,
  input logic signed [47:0]  q_yy_o,
  input logic signed [47:0]  q_yz_o,
  input logic signed [47:0]  q_yw_o,
  input logic signed [47:0]  q_zz_o,
  input logic signed [47:0]  q_zw_o,
  input logic signed [47:0]  q_ww_o,
  input logic                saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(q_xx_o) && $stable(q_xy_o) && $stable(q_xz_o)
      && $stable(q_xw_o) && $stable(q_yy_o) && $stable(q_yz_o) && $stable(q_yw_o)
      && $stable(q_zz_o) && $stable(q_zw_o) && $stable(q_ww_o) && $stable(saturated_o))
    else $error("Result payload changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again before the previous request was processed.");

  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o && $past(in_stall_o))
    else $error("Result appeared without a request finishing.");

endmodule

bind plane_quadric_accumulator pqa_chk u_pqa_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for plane_quadric_accumulator: directed and random face streams checked against a quadric predictor.
module testbench;

  localparam int unsigned SUM_FRAC = 16;
  localparam int unsigned LONG_HOLD = 5000;
  localparam int unsigned TAIL_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned PHASE_REQUESTS = 340;
  localparam logic signed [63:0] ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [23:0] normal_x;
    logic signed [23:0] normal_y;
    logic signed [23:0] normal_z;
    logic               face_valid;
    logic               last_face;
  } face_req_t;

  typedef struct packed {
    logic [pqa_pkg::NUM_SUMS-1:0][pqa_pkg::SUM_W-1:0] entry;
    logic                                             saturated;
  } quadric_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic signed [15:0] pos_z_i = '0;
  logic signed [23:0] normal_x_i = '0;
  logic signed [23:0] normal_y_i = '0;
  logic signed [23:0] normal_z_i = '0;
  logic               face_valid_i = 1'b0;
  logic               last_face_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [47:0] q_xx_o, q_xy_o, q_xz_o, q_xw_o, q_yy_o;
  logic signed [47:0] q_yz_o, q_yw_o, q_zz_o, q_zw_o, q_ww_o;
  logic               saturated_o;

  face_req_t   pending_faces [$];
  quadric_t    expected_quadrics [$];
  face_req_t   offered_face;

  logic signed [pqa_pkg::SUM_W-1:0] quadric_acc [pqa_pkg::NUM_SUMS];
  bit                               acc_saturated;

  string entry_names [pqa_pkg::NUM_SUMS] = '{"q_xx", "q_xy", "q_xz", "q_xw", "q_yy",
                                             "q_yz", "q_yw", "q_zz", "q_zw", "q_ww"};

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_offs_asked = 0;
  int unsigned hold_offs_granted = 0;
  int unsigned hold_off_left = 0;
  longint      cycle_count = 0;
  int unsigned failures = 0;
  int unsigned faces_queued = 0;
  int unsigned faces_accepted = 0;
  int unsigned faces_added = 0;
  int unsigned zero_normals = 0;
  int unsigned results_checked = 0;

  plane_quadric_accumulator #(
    .SUM_FRAC_BITS(SUM_FRAC)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .pos_z_i(pos_z_i),
    .normal_x_i(normal_x_i),
    .normal_y_i(normal_y_i),
    .normal_z_i(normal_z_i),
    .face_valid_i(face_valid_i),
    .last_face_i(last_face_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .q_xx_o(q_xx_o),
    .q_xy_o(q_xy_o),
    .q_xz_o(q_xz_o),
    .q_xw_o(q_xw_o),
    .q_yy_o(q_yy_o),
    .q_yz_o(q_yz_o),
    .q_yw_o(q_yw_o),
    .q_zz_o(q_zz_o),
    .q_zw_o(q_zw_o),
    .q_ww_o(q_ww_o),
    .saturated_o(saturated_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One plane product p_a * p_b / |n|^2, truncated toward zero and clamped to 48 bits.
  function automatic logic signed [pqa_pkg::SUM_W-1:0] plane_term(
      input logic signed [63:0] a,
      input logic signed [63:0] b,
      input logic [63:0] n2,
      input int unsigned fsh,
      output bit clamped);
    logic [127:0] ma, mb, x, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    x = ma * mb;
    x = (x << SUM_FRAC) / {64'd0, n2};
    x = x >> fsh;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    clamped = 1'b0;
    if (x > lim) begin
      clamped = 1'b1;
      x = lim;
    end
    return neg ? -x[pqa_pkg::SUM_W-1:0] : x[pqa_pkg::SUM_W-1:0];
  endfunction

  task automatic add_face_to_quadric(input face_req_t f);
    logic signed [63:0] nx, ny, nz, px, py, pz;
    logic signed [63:0] plane [4];
    logic [63:0] n2;
    logic signed [pqa_pkg::SUM_W-1:0] t;
    logic signed [63:0] s;
    bit clamped;
    int k;
    quadric_t res;
    nx = f.normal_x;
    ny = f.normal_y;
    nz = f.normal_z;
    px = f.pos_x;
    py = f.pos_y;
    pz = f.pos_z;
    n2 = nx * nx + ny * ny + nz * nz;
    if (f.face_valid && n2 != 0) begin
      plane[0] = nx;
      plane[1] = ny;
      plane[2] = nz;
      plane[3] = -(nx * px + ny * py + nz * pz);
      k = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = i; j < 4; j++) begin
          t = plane_term(plane[i], plane[j], n2,
                         (i == pqa_pkg::P_W ? pqa_pkg::POS_FRAC_BITS : 0) +
                         (j == pqa_pkg::P_W ? pqa_pkg::POS_FRAC_BITS : 0),
                         clamped);
          s = quadric_acc[k] + t;
          if (s > ACC_HI) begin
            s = ACC_HI;
            clamped = 1'b1;
          end else if (s < ACC_LO) begin
            s = ACC_LO;
            clamped = 1'b1;
          end
          quadric_acc[k] = s[pqa_pkg::SUM_W-1:0];
          if (clamped) acc_saturated = 1'b1;
          k++;
        end
      end
      faces_added++;
    end else if (f.face_valid) begin
      zero_normals++;
    end
    if (f.last_face) begin
      for (k = 0; k < pqa_pkg::NUM_SUMS; k++) begin
        res.entry[k] = quadric_acc[k];
        quadric_acc[k] = '0;
      end
      res.saturated = acc_saturated;
      acc_saturated = 1'b0;
      expected_quadrics = {expected_quadrics, res};
    end
  endtask

  task automatic note_failure(input string what, input longint want_v, input longint got_v);
    failures++;
    if (failures <= REPORT_MAX)
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               what, cycle_count, want_v, got_v);
  endtask

  task automatic compare_quadric();
    quadric_t want;
    logic [pqa_pkg::SUM_W-1:0] got [pqa_pkg::NUM_SUMS];
    int k;
    got[0] = q_xx_o;
    got[1] = q_xy_o;
    got[2] = q_xz_o;
    got[3] = q_xw_o;
    got[4] = q_yy_o;
    got[5] = q_yz_o;
    got[6] = q_yw_o;
    got[7] = q_zz_o;
    got[8] = q_zw_o;
    got[9] = q_ww_o;
    results_checked++;
    if (expected_quadrics.size() == 0) begin
      failures++;
      if (failures <= REPORT_MAX)
        $display("quadric result at cycle %0d with no request waiting for it", cycle_count);
    end else begin
      want = expected_quadrics.pop_front();
      for (k = 0; k < pqa_pkg::NUM_SUMS; k++)
        if (want.entry[k] !== got[k])
          note_failure(entry_names[k], $signed(want.entry[k]), $signed(got[k]));
      if (want.saturated !== saturated_o)
        note_failure("saturated", want.saturated, saturated_o);
    end
  endtask

  always @(posedge clk_i) begin : drive_faces
    bit offer;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        add_face_to_quadric(offered_face);
        faces_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        offer = pending_faces.size() != 0 && $urandom_range(99) >= sender_idle_pct;
        if (offer) begin
          offered_face = pending_faces.pop_front();
          pos_x_i <= offered_face.pos_x;
          pos_y_i <= offered_face.pos_y;
          pos_z_i <= offered_face.pos_z;
          normal_x_i <= offered_face.normal_x;
          normal_y_i <= offered_face.normal_y;
          normal_z_i <= offered_face.normal_z;
          face_valid_i <= offered_face.face_valid;
          last_face_i <= offered_face.last_face;
        end
        in_valid_i <= offer;
      end
    end
  end

  always @(posedge clk_i) begin : check_quadrics
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) compare_quadric();
      out_stall_i <= hold_off_left != 0 || $urandom_range(99) < receiver_stall_pct;
    end
  end

  always @(posedge clk_i) begin : hold_off_timer
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (hold_offs_granted < hold_offs_asked) begin
      hold_off_left <= LONG_HOLD;
      hold_offs_granted <= hold_offs_granted + 1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("plane_quadric_accumulator test failed");
      $finish;
    end
  end

  task automatic push_face(input logic [15:0] px, input logic [15:0] py, input logic [15:0] pz,
                           input logic [23:0] nx, input logic [23:0] ny, input logic [23:0] nz,
                           input logic fv, input logic lf);
    face_req_t f;
    f.pos_x = px;
    f.pos_y = py;
    f.pos_z = pz;
    f.normal_x = nx;
    f.normal_y = ny;
    f.normal_z = nz;
    f.face_valid = fv;
    f.last_face = lf;
    pending_faces = {pending_faces, f};
    faces_queued++;
  endtask

  function automatic logic [23:0] random_normal_part(input int unsigned style);
    logic [23:0] v;
    case (style)
      0: v = 24'($urandom);
      1: v = 24'($urandom_range(200)) - 24'd100;
      2: v = 24'($urandom_range(8190)) - 24'd4095;
      default: begin
        case ($urandom_range(4))
          0: v = 24'h800000;
          1: v = 24'h7FFFFF;
          2: v = 24'h000000;
          3: v = 24'h000001;
          default: v = 24'hFFFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] random_pos_part(input int unsigned style);
    logic [15:0] v;
    case (style)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(1024)) - 16'd512;
      default: begin
        case ($urandom_range(4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic queue_vertex();
    logic [15:0] px, py, pz;
    logic [23:0] nx, ny, nz;
    int unsigned faces, pos_style, nrm_style, kind;
    pos_style = $urandom_range(2);
    px = random_pos_part(pos_style);
    py = random_pos_part(pos_style);
    pz = random_pos_part(pos_style);
    faces = $urandom_range(9) == 0 ? $urandom_range(12, 5) : $urandom_range(4);
    if (faces == 0)
      push_face(px, py, pz, 24'($urandom), 24'($urandom), 24'($urandom), 1'b0, 1'b1);
    for (int f = 0; f < faces; f++) begin
      if ($urandom_range(11) == 0)
        push_face(px, py, pz, 24'($urandom), 24'($urandom), 24'($urandom), 1'b0, 1'b0);
      kind = $urandom_range(15);
      nrm_style = $urandom_range(3);
      nx = random_normal_part(nrm_style);
      ny = random_normal_part(nrm_style);
      nz = random_normal_part(nrm_style);
      if (kind == 0) begin
        nx = '0;
        ny = '0;
        nz = '0;
      end else if (kind == 1) begin
        ny = '0;
        nz = '0;
      end else if (kind == 2) begin
        nx = '0;
        nz = '0;
      end
      push_face(px, py, pz, nx, ny, nz, 1'b1, f == faces - 1);
    end
  endtask

  task automatic queue_random_phase(input int unsigned count);
    int unsigned start;
    start = faces_queued;
    while (faces_queued - start < count) begin
      if ($urandom_range(99) < 12)
        push_face(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 1'($urandom), 1'($urandom));
      else
        queue_vertex();
    end
  endtask

  task automatic wait_until_drained();
    while (pending_faces.size() != 0 || in_valid_i || expected_quadrics.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    for (int k = 0; k < pqa_pkg::NUM_SUMS; k++) quadric_acc[k] = '0;
    acc_saturated = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A vertex with no faces, extreme positions and normals, and zero normals.
    push_face(16'h0000, 16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1);
    push_face(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1);
    push_face(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1);
    push_face(16'h7FFF, 16'h8000, 16'h0001, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 1'b0);
    push_face(16'd100, -16'd200, 16'd300, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b0);
    push_face(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd5, 24'd5, 24'd5, 1'b0, 1'b0);
    push_face(16'd256, 16'd0, 16'd0, 24'd3, -24'd4, 24'd12, 1'b1, 1'b1);
    push_face(16'h7FFF, 16'h0000, 16'h0000, 24'd1, 24'd0, 24'd0, 1'b1, 1'b1);
    push_face(16'd1, 16'd0, 16'd0, 24'd1, 24'd1, 24'd1, 1'b1, 1'b1);
    push_face(16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
    push_face(16'h8000, 16'h7FFF, 16'h8000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    push_face(16'd12345, -16'd23456, 16'd7, -24'd1, 24'd2, -24'd3, 1'b1, 1'b0);
    push_face(-16'd7, 16'd7, -16'd7, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1);
    push_face(16'd0, 16'd0, -16'd256, 24'd0, 24'd0, -24'd1, 1'b1, 1'b0);
    push_face(16'd0, 16'd0, -16'd256, 24'd0, 24'h800000, 24'd0, 1'b1, 1'b1);
    push_face(16'h8000, 16'h8000, 16'h8000, 24'd1, 24'd1, 24'd1, 1'b0, 1'b1);
    wait_until_drained();

    // The receiver holds off for a long stretch so that the block backs up.
    hold_offs_asked++;
    queue_random_phase(PHASE_REQUESTS);
    wait_until_drained();

    sender_idle_pct = 56;
    queue_random_phase(PHASE_REQUESTS);
    wait_until_drained();

    sender_idle_pct = 0;
    receiver_stall_pct = 56;
    queue_random_phase(PHASE_REQUESTS);
    wait_until_drained();

    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    queue_random_phase(PHASE_REQUESTS);
    wait_until_drained();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    queue_random_phase(PHASE_REQUESTS);
    wait_until_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_quadrics.size() != 0) begin
      failures += expected_quadrics.size();
      $display("%0d expected quadric results never arrived", expected_quadrics.size());
    end

    $display("covered %0d requests: %0d faces summed, %0d zero normals skipped",
             faces_accepted, faces_added, zero_normals);
    $display("compared %0d vertex quadrics over %0d cycles, %0d failures",
             results_checked, cycle_count, failures);
    if (failures == 0) begin
      $display("plane_quadric_accumulator test passed");
    end else begin
      $display("plane_quadric_accumulator test failed");
    end
    $finish;
  end

endmodule
